@@ src/bgs_pkg.sv @@
`timescale 1ns / 1ps

package bgs_pkg;

  // default frame geometry
  localparam int DEF_FRAME_WIDTH  = 640;
  localparam int DEF_FRAME_HEIGHT = 480;

  // config port geometry
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // operation codes carried by each input word
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BG_THRESHOLD = 3'd0,
    REG_FD_THRESHOLD = 3'd1,
    REG_WEIGHT_Y     = 3'd2,
    REG_WEIGHT_CBCR  = 3'd3,
    REG_ALPHA_KEEP   = 3'd4,
    REG_ALPHA_NEW    = 3'd5,
    REG_BOX_COLUMNS  = 3'd6,
    REG_BOX_ROWS     = 3'd7
  } cfg_idx_t;

  // register reset values
  localparam logic [31:0] RST_BG_THRESHOLD = 32'd1966080;
  localparam logic [7:0]  RST_FD_THRESHOLD = 8'd30;
  localparam logic [15:0] RST_WEIGHT_Y     = 16'd384;
  localparam logic [15:0] RST_WEIGHT_CBCR  = 16'd256;
  localparam logic [16:0] RST_ALPHA_KEEP   = 17'd62536;
  localparam logic [16:0] RST_ALPHA_NEW    = 17'd3000;
  localparam logic [31:0] RST_BOX_COLUMNS  = 32'd0;
  localparam logic [31:0] RST_BOX_ROWS     = 32'd0;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [31:0] bg_threshold;
    logic [7:0]  fd_threshold;
    logic [15:0] weight_y;
    logic [15:0] weight_cbcr;
    logic [16:0] alpha_keep;
    logic [16:0] alpha_new;
    logic [31:0] box_columns;
    logic [31:0] box_rows;
  } cfg_t;

  // one stored pixel entry: 8.8 background per channel and last luma
  typedef struct packed {
    logic [15:0] bg_y;
    logic [15:0] bg_cb;
    logic [15:0] bg_cr;
    logic [7:0]  luma;
  } entry_t;

endpackage

@@ src/bgs_pix_if.sv @@
`timescale 1ns / 1ps

interface bgs_pix_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel_y;
  logic [7:0] pixel_cb;
  logic [7:0] pixel_cr;
  logic [9:0] column;
  logic [8:0] row;

  modport source (
    output valid, op, pixel_y, pixel_cb, pixel_cr, column, row,
    input  ready
  );

  modport sink (
    input  valid, op, pixel_y, pixel_cb, pixel_cr, column, row,
    output ready
  );
endinterface

@@ src/bgs_res_if.sv @@
`timescale 1ns / 1ps

interface bgs_res_if;
  logic       valid;
  logic       ready;
  logic       foreground;
  logic       motion;
  logic [7:0] background_y;
  logic [7:0] background_cb;
  logic [7:0] background_cr;

  modport source (
    output valid, foreground, motion, background_y, background_cb, background_cr,
    input  ready
  );

  modport sink (
    input  valid, foreground, motion, background_y, background_cb, background_cr,
    output ready
  );
endinterface

@@ src/bgs_cfg.sv @@
`timescale 1ns / 1ps

module bgs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bgs_pkg::cfg_t                     cfg
);

  bgs_pkg::cfg_t    cfg_r;
  bgs_pkg::cfg_idx_t idx;

  assign idx = bgs_pkg::cfg_idx_t'(cfg_index);

  // register file, written field by field, masked to width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_threshold <= bgs_pkg::RST_BG_THRESHOLD;
      cfg_r.fd_threshold <= bgs_pkg::RST_FD_THRESHOLD;
      cfg_r.weight_y     <= bgs_pkg::RST_WEIGHT_Y;
      cfg_r.weight_cbcr  <= bgs_pkg::RST_WEIGHT_CBCR;
      cfg_r.alpha_keep   <= bgs_pkg::RST_ALPHA_KEEP;
      cfg_r.alpha_new    <= bgs_pkg::RST_ALPHA_NEW;
      cfg_r.box_columns  <= bgs_pkg::RST_BOX_COLUMNS;
      cfg_r.box_rows     <= bgs_pkg::RST_BOX_ROWS;
    end else if (cfg_we) begin
      case (idx)
        bgs_pkg::REG_BG_THRESHOLD: cfg_r.bg_threshold <= cfg_data;
        bgs_pkg::REG_FD_THRESHOLD: cfg_r.fd_threshold <= cfg_data[7:0];
        bgs_pkg::REG_WEIGHT_Y:     cfg_r.weight_y     <= cfg_data[15:0];
        bgs_pkg::REG_WEIGHT_CBCR:  cfg_r.weight_cbcr  <= cfg_data[15:0];
        bgs_pkg::REG_ALPHA_KEEP:   cfg_r.alpha_keep   <= cfg_data[16:0];
        bgs_pkg::REG_ALPHA_NEW:    cfg_r.alpha_new    <= cfg_data[16:0];
        bgs_pkg::REG_BOX_COLUMNS:  cfg_r.box_columns  <= cfg_data;
        bgs_pkg::REG_BOX_ROWS:     cfg_r.box_rows     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/bgs_store.sv @@
`timescale 1ns / 1ps

module bgs_store #(
  parameter int DEPTH  = bgs_pkg::DEF_FRAME_WIDTH * bgs_pkg::DEF_FRAME_HEIGHT,
  parameter int ADDR_W = 19
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  bgs_pkg::entry_t   wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output bgs_pkg::entry_t   rdata
);

  bgs_pkg::entry_t mem [DEPTH];
  bgs_pkg::entry_t rdata_r;

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/background_subtraction_pixel_core.sv @@
`timescale 1ns / 1ps

// Running-average background subtraction on a YCbCr pixel stream. One pixel word is
// taken per clock unless a held-back pixel or output back-pressure stalls the input;
// its result passes address, memory read, differences, products, decision and
// write-back into the output register. Each pixel owns one entry of a FRAME_WIDTH x
// FRAME_HEIGHT store (8.8 background per channel plus the last luma); the store has
// no reset, so a pixel must be loaded (op 0) before it is segmented (op 1). The entry
// is read in the second stage and written back at the end of the fourth, so a pixel
// whose column and row match one still in the first four stages waits until that one
// has written back (a repeated pixel waits, a normal raster scan does not). Pixels
// outside the frame are passed through with an all-zero result and touch no state.
// The user writes configuration through the cfg port only while the pipeline is empty; the block does not enforce it.
module background_subtraction_pixel_core #(
  parameter int FRAME_WIDTH  = bgs_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = bgs_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bgs_pix_if.sink                         in_pix,
  bgs_res_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [bgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [31:0] FW_W = 32'(FRAME_WIDTH);
  localparam logic [31:0] FH_W = 32'(FRAME_HEIGHT);

  function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [15:0] sat16(input logic [33:0] sum);
    logic [17:0] sh;
    sh = sum[33:16];
    return (sh[17:16] != 2'b00) ? 16'hFFFF : sh[15:0];
  endfunction

  bgs_pkg::cfg_t cfg;

  bgs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------- flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic hazard, accept;

  logic [9:0] s1_col_r, s2_col_r, s3_col_r, s4_col_r;
  logic [8:0] s1_row_r, s2_row_r, s3_row_r, s4_row_r;

  assign rdy_out = !out_v_r || out_res.ready;
  assign rdy4    = !s4_v_r  || rdy_out;
  assign rdy3    = !s3_v_r  || rdy4;
  assign rdy2    = !s2_v_r  || rdy3;
  assign rdy1    = !s1_v_r  || rdy2;

  // hold a pixel back while the same position is still before write-back
  assign hazard = (s1_v_r && s1_col_r == in_pix.column && s1_row_r == in_pix.row)
               || (s2_v_r && s2_col_r == in_pix.column && s2_row_r == in_pix.row)
               || (s3_v_r && s3_col_r == in_pix.column && s3_row_r == in_pix.row)
               || (s4_v_r && s4_col_r == in_pix.column && s4_row_r == in_pix.row);

  assign in_pix.ready = rst_n && rdy1 && !hazard;
  assign accept       = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)    s1_v_r  <= accept;
      if (rdy2)    s2_v_r  <= s1_v_r;
      if (rdy3)    s3_v_r  <= s2_v_r;
      if (rdy4)    s4_v_r  <= s3_v_r;
      if (rdy_out) out_v_r <= s4_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: address
  logic [31:0]       addr_full;
  logic              in_frame_nxt, box_hit_nxt;
  logic [15:0]       col16, row16;

  logic              s1_op_r, s1_frame_r, s1_box_r;
  logic [7:0]        s1_py_r, s1_pcb_r, s1_pcr_r;
  logic [ADDR_W-1:0] s1_addr_r;

  assign col16     = 16'(in_pix.column);
  assign row16     = 16'(in_pix.row);
  assign addr_full = 32'(in_pix.row) * FW_W + 32'(in_pix.column);
  assign in_frame_nxt = (32'(in_pix.column) < FW_W) && (32'(in_pix.row) < FH_W);

  // reload box, bounds included, disabled by a last column of zero
  assign box_hit_nxt = (cfg.box_columns[31:16] != 16'd0)
                    && (col16 >= cfg.box_columns[15:0]) && (col16 <= cfg.box_columns[31:16])
                    && (row16 >= cfg.box_rows[15:0])    && (row16 <= cfg.box_rows[31:16]);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_pix.op;
      s1_py_r    <= in_pix.pixel_y;
      s1_pcb_r   <= in_pix.pixel_cb;
      s1_pcr_r   <= in_pix.pixel_cr;
      s1_col_r   <= in_pix.column;
      s1_row_r   <= in_pix.row;
      s1_frame_r <= in_frame_nxt;
      s1_box_r   <= box_hit_nxt;
      s1_addr_r  <= addr_full[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------- pixel store
  logic              mem_we, mem_re;
  bgs_pkg::entry_t   mem_wdata, mem_q;
  logic [ADDR_W-1:0] s4_addr_r;

  assign mem_re = s1_v_r && rdy2 && s1_frame_r;

  bgs_store #(
    .DEPTH  (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s4_addr_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (s1_addr_r),
    .rdata (mem_q)
  );

  // ---------------------------------------------------------------- stage 2: differences
  logic              s2_op_r, s2_frame_r, s2_box_r;
  logic [7:0]        s2_py_r, s2_pcb_r, s2_pcr_r;
  logic [ADDR_W-1:0] s2_addr_r;

  logic [15:0] dy_nxt, dcb_nxt, dcr_nxt;
  logic [16:0] dc_nxt;
  logic [7:0]  dluma_nxt;
  logic        mo_nxt;

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_op_r    <= s1_op_r;
      s2_py_r    <= s1_py_r;
      s2_pcb_r   <= s1_pcb_r;
      s2_pcr_r   <= s1_pcr_r;
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      s2_frame_r <= s1_frame_r;
      s2_box_r   <= s1_box_r;
      s2_addr_r  <= s1_addr_r;
    end
  end

  assign dy_nxt    = absdiff16({s2_py_r, 8'h00},  mem_q.bg_y);
  assign dcb_nxt   = absdiff16({s2_pcb_r, 8'h00}, mem_q.bg_cb);
  assign dcr_nxt   = absdiff16({s2_pcr_r, 8'h00}, mem_q.bg_cr);
  assign dc_nxt    = 17'(dcb_nxt) + 17'(dcr_nxt);
  assign dluma_nxt = (s2_py_r >= mem_q.luma) ? (s2_py_r - mem_q.luma) : (mem_q.luma - s2_py_r);
  assign mo_nxt    = dluma_nxt > cfg.fd_threshold;

  // ---------------------------------------------------------------- stage 3: products
  logic              s3_op_r, s3_frame_r, s3_box_r, s3_mo_r;
  logic [7:0]        s3_py_r, s3_pcb_r, s3_pcr_r;
  logic [ADDR_W-1:0] s3_addr_r;
  logic [15:0]       s3_dy_r;
  logic [16:0]       s3_dc_r;
  logic [15:0]       s3_bgy_r, s3_bgcb_r, s3_bgcr_r;

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_op_r    <= s2_op_r;
      s3_py_r    <= s2_py_r;
      s3_pcb_r   <= s2_pcb_r;
      s3_pcr_r   <= s2_pcr_r;
      s3_col_r   <= s2_col_r;
      s3_row_r   <= s2_row_r;
      s3_frame_r <= s2_frame_r;
      s3_box_r   <= s2_box_r;
      s3_addr_r  <= s2_addr_r;
      s3_mo_r    <= mo_nxt;
      s3_dy_r    <= dy_nxt;
      s3_dc_r    <= dc_nxt;
      s3_bgy_r   <= mem_q.bg_y;
      s3_bgcb_r  <= mem_q.bg_cb;
      s3_bgcr_r  <= mem_q.bg_cr;
    end
  end

  // ---------------------------------------------------------------- stage 4: decision
  logic              s4_op_r, s4_frame_r, s4_box_r, s4_mo_r;
  logic [7:0]        s4_py_r, s4_pcb_r, s4_pcr_r;
  logic [15:0]       s4_bgy_r, s4_bgcb_r, s4_bgcr_r;
  logic [31:0]       s4_wy_r;
  logic [32:0]       s4_wc_r;
  logic [32:0]       s4_ky_r, s4_kcb_r, s4_kcr_r;
  logic [32:0]       s4_ny_r, s4_ncb_r, s4_ncr_r;

  // distance terms and blend terms, all independent multipliers
  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_op_r    <= s3_op_r;
      s4_py_r    <= s3_py_r;
      s4_pcb_r   <= s3_pcb_r;
      s4_pcr_r   <= s3_pcr_r;
      s4_col_r   <= s3_col_r;
      s4_row_r   <= s3_row_r;
      s4_frame_r <= s3_frame_r;
      s4_box_r   <= s3_box_r;
      s4_addr_r  <= s3_addr_r;
      s4_mo_r    <= s3_mo_r;
      s4_bgy_r   <= s3_bgy_r;
      s4_bgcb_r  <= s3_bgcb_r;
      s4_bgcr_r  <= s3_bgcr_r;
      s4_wy_r    <= 32'(cfg.weight_y) * 32'(s3_dy_r);
      s4_wc_r    <= 33'(cfg.weight_cbcr) * 33'(s3_dc_r);
      s4_ky_r    <= 33'(s3_bgy_r)  * 33'(cfg.alpha_keep);
      s4_kcb_r   <= 33'(s3_bgcb_r) * 33'(cfg.alpha_keep);
      s4_kcr_r   <= 33'(s3_bgcr_r) * 33'(cfg.alpha_keep);
      s4_ny_r    <= 33'({s3_py_r, 8'h00})  * 33'(cfg.alpha_new);
      s4_ncb_r   <= 33'({s3_pcb_r, 8'h00}) * 33'(cfg.alpha_new);
      s4_ncr_r   <= 33'({s3_pcr_r, 8'h00}) * 33'(cfg.alpha_new);
    end
  end

  logic [33:0] distance;
  logic        fg_seg, seg, fg_nxt, mo_out_nxt, blend_en, reload;
  logic [15:0] new_y, new_cb, new_cr;

  assign distance = 34'(s4_wy_r) + 34'(s4_wc_r);
  assign fg_seg   = distance > 34'(cfg.bg_threshold);
  assign seg      = s4_op_r == bgs_pkg::OP_SEGMENT;

  assign fg_nxt     = s4_frame_r && seg && fg_seg;
  assign mo_out_nxt = s4_frame_r && seg && s4_mo_r;

  // load and box reload take the pixel, still pixels blend, others keep
  assign reload   = !seg || s4_box_r;
  assign blend_en = !fg_seg && !s4_mo_r;

  always_comb begin
    if (reload) begin
      new_y  = {s4_py_r, 8'h00};
      new_cb = {s4_pcb_r, 8'h00};
      new_cr = {s4_pcr_r, 8'h00};
    end else if (blend_en) begin
      new_y  = sat16(34'(s4_ky_r)  + 34'(s4_ny_r));
      new_cb = sat16(34'(s4_kcb_r) + 34'(s4_ncb_r));
      new_cr = sat16(34'(s4_kcr_r) + 34'(s4_ncr_r));
    end else begin
      new_y  = s4_bgy_r;
      new_cb = s4_bgcb_r;
      new_cr = s4_bgcr_r;
    end
  end

  // write-back as the word moves to the output register
  assign mem_we          = s4_v_r && rdy_out && s4_frame_r;
  assign mem_wdata.bg_y  = new_y;
  assign mem_wdata.bg_cb = new_cb;
  assign mem_wdata.bg_cr = new_cr;
  assign mem_wdata.luma  = s4_py_r;

  // ---------------------------------------------------------------- output register
  logic       out_fg_r, out_mo_r;
  logic [7:0] out_y_r, out_cb_r, out_cr_r;

  always_ff @(posedge clk) begin
    if (rdy_out && s4_v_r) begin
      out_fg_r <= fg_nxt;
      out_mo_r <= mo_out_nxt;
      out_y_r  <= s4_frame_r ? new_y[15:8]  : 8'h00;
      out_cb_r <= s4_frame_r ? new_cb[15:8] : 8'h00;
      out_cr_r <= s4_frame_r ? new_cr[15:8] : 8'h00;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.foreground    = out_fg_r;
  assign out_res.motion        = out_mo_r;
  assign out_res.background_y  = out_y_r;
  assign out_res.background_cb = out_cb_r;
  assign out_res.background_cr = out_cr_r;

  // ---------------------------------------------------------------- assertions
  a_s1_s2_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r) |-> !(s1_col_r == s2_col_r && s1_row_r == s2_row_r))
    else $error("same pixel in stage 1 and stage 2");

  a_s2_s3_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s3_v_r) |-> !(s2_col_r == s3_col_r && s2_row_r == s3_row_r))
    else $error("same pixel in stage 2 and stage 3");

  a_s1_s4_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s4_v_r) |-> !(s1_col_r == s4_col_r && s1_row_r == s4_row_r))
    else $error("pixel read before its earlier write-back");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (s4_addr_r != s1_addr_r))
    else $error("store read and write hit the same entry");

endmodule

@@ bench/background_subtraction_pixel_core_tb.sv @@
`timescale 1ns / 1ps

module background_subtraction_pixel_core_tb;

  localparam int FRAME_W  = bgs_pkg::DEF_FRAME_WIDTH;
  localparam int FRAME_H  = bgs_pkg::DEF_FRAME_HEIGHT;
  localparam int HOT_COL  = 100;
  localparam int HOT_ROW  = 200;
  localparam int SETTLE   = 8;

  // one pixel word and one result word
  typedef struct packed {
    logic       op;
    logic [7:0] pixel_y;
    logic [7:0] pixel_cb;
    logic [7:0] pixel_cr;
    logic [9:0] column;
    logic [8:0] row;
  } pix_word_t;

  typedef struct packed {
    logic       foreground;
    logic       motion;
    logic [7:0] background_y;
    logic [7:0] background_cb;
    logic [7:0] background_cr;
  } px_result_t;

  typedef enum int {SET_RESET, SET_MAX, SET_ZERO, SET_RANDOM} setting_kind_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bgs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_data;

  bgs_pix_if pix_bus ();
  bgs_res_if res_bus ();

  background_subtraction_pixel_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_bus),
    .out_res   (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block: configuration and per-pixel entries
  bgs_pkg::cfg_t   shadow_cfg;
  bgs_pkg::entry_t pixel_store [int];
  int              loaded_addrs [$];
  px_result_t      due_results [$];

  bit          idle_on = 1'b1;
  int unsigned res_hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_loads = 0, n_segments = 0, n_ignored = 0;
  int unsigned n_fg = 0, n_motion = 0, n_settings = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // gap lengths: mostly short, a few long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] abs_gap(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  // running average of one channel, saturated to 16 bits
  function automatic logic [15:0] blend_chan(input logic [15:0] old_v, input logic [7:0] pix);
    logic [63:0] mix;
    mix = (64'(old_v) * 64'(shadow_cfg.alpha_keep)
           + 64'({pix, 8'h00}) * 64'(shadow_cfg.alpha_new)) >> 16;
    return (mix > 64'd65535) ? 16'hFFFF : mix[15:0];
  endfunction

  // segment or load one pixel against the shadow store
  function automatic px_result_t segment_pixel(input pix_word_t w);
    px_result_t      r;
    bgs_pkg::entry_t e;
    int              addr;
    logic [63:0]     distance;
    logic [15:0]     first_col, last_col, first_row, last_row;
    r = '0;
    if (w.column >= FRAME_W || w.row >= FRAME_H) return r;
    addr = int'(w.row) * FRAME_W + int'(w.column);
    if (w.op == bgs_pkg::OP_LOAD) begin
      e.bg_y  = {w.pixel_y, 8'h00};
      e.bg_cb = {w.pixel_cb, 8'h00};
      e.bg_cr = {w.pixel_cr, 8'h00};
      e.luma  = w.pixel_y;
    end else begin
      e = pixel_store.exists(addr) ? pixel_store[addr] : '0;
      distance = 64'(shadow_cfg.weight_y) * abs_gap({w.pixel_y, 8'h00}, e.bg_y)
               + 64'(shadow_cfg.weight_cbcr) * (abs_gap({w.pixel_cb, 8'h00}, e.bg_cb)
                                                + abs_gap({w.pixel_cr, 8'h00}, e.bg_cr));
      r.foreground = distance > 64'(shadow_cfg.bg_threshold);
      r.motion = abs_gap({8'h00, w.pixel_y}, {8'h00, e.luma}) > 64'(shadow_cfg.fd_threshold);
      e.luma = w.pixel_y;
      // still background drifts toward the pixel
      if (!r.foreground && !r.motion) begin
        e.bg_y  = blend_chan(e.bg_y, w.pixel_y);
        e.bg_cb = blend_chan(e.bg_cb, w.pixel_cb);
        e.bg_cr = blend_chan(e.bg_cr, w.pixel_cr);
      end
      // reload box overrides the blend
      {last_col, first_col} = shadow_cfg.box_columns;
      {last_row, first_row} = shadow_cfg.box_rows;
      if (last_col != 16'd0 && w.column >= first_col && w.column <= last_col &&
          w.row >= first_row && w.row <= last_row) begin
        e.bg_y  = {w.pixel_y, 8'h00};
        e.bg_cb = {w.pixel_cb, 8'h00};
        e.bg_cr = {w.pixel_cr, 8'h00};
      end
    end
    pixel_store[addr] = e;
    r.background_y  = e.bg_y[15:8];
    r.background_cb = e.bg_cb[15:8];
    r.background_cr = e.bg_cr[15:8];
    return r;
  endfunction

  function automatic pix_word_t mk_pixel(input logic op, input int y, input int cb, input int cr,
                                         input int col, input int row);
    pix_word_t w;
    w.op       = op;
    w.pixel_y  = y[7:0];
    w.pixel_cb = cb[7:0];
    w.pixel_cr = cr[7:0];
    w.column   = col[9:0];
    w.row      = row[8:0];
    return w;
  endfunction

  function automatic logic [7:0] near_byte(input logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly loads and segments of loaded pixels, some out-of-frame noise
  function automatic pix_word_t random_pixel();
    pix_word_t       w;
    bgs_pkg::entry_t e;
    int              addr;
    int              r;
    int              m;
    w = mk_pixel(bgs_pkg::OP_SEGMENT, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), 0, 0);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      w.op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        w.column = 10'($urandom_range(FRAME_W, 1023));
        w.row    = 9'($urandom_range(0, 511));
      end else begin
        w.column = 10'($urandom_range(0, 1023));
        w.row    = 9'($urandom_range(FRAME_H, 511));
      end
      return w;
    end
    if (r < 45)
      addr = (HOT_ROW + $urandom_range(0, 1)) * FRAME_W + HOT_COL + $urandom_range(0, 7);
    else if (r < 50)
      addr = ($urandom_range(0, 1) ? FRAME_H - 1 : 0) * FRAME_W
           + ($urandom_range(0, 1) ? FRAME_W - 1 : 0);
    else if (r < 62 || loaded_addrs.size() == 0)
      addr = $urandom_range(0, FRAME_H - 1) * FRAME_W + $urandom_range(0, FRAME_W - 1);
    else
      addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
    w.column = 10'(addr % FRAME_W);
    w.row    = 9'(addr / FRAME_W);
    if (!pixel_store.exists(addr) || $urandom_range(0, 99) < 12) begin
      w.op = bgs_pkg::OP_LOAD;
      if (!pixel_store.exists(addr)) loaded_addrs.push_back(addr);
      return w;
    end
    e = pixel_store[addr];
    m = $urandom_range(0, 9);
    if (m < 6) begin
      w.pixel_y  = near_byte(e.bg_y[15:8]);
      w.pixel_cb = near_byte(e.bg_cb[15:8]);
      w.pixel_cr = near_byte(e.bg_cr[15:8]);
    end else if (m < 7) begin
      w.pixel_y  = e.bg_y[15:8];
      w.pixel_cb = e.bg_cb[15:8];
      w.pixel_cr = e.bg_cr[15:8];
    end
    return w;
  endfunction

  // register settings: reset values, extremes or random
  function automatic bgs_pkg::cfg_t preset_setting(input setting_kind_t kind);
    bgs_pkg::cfg_t c;
    logic [15:0] fc, lc, fr, lr;
    c = '0;
    case (kind)
      SET_RESET: begin
        c.bg_threshold = bgs_pkg::RST_BG_THRESHOLD;
        c.fd_threshold = bgs_pkg::RST_FD_THRESHOLD;
        c.weight_y     = bgs_pkg::RST_WEIGHT_Y;
        c.weight_cbcr  = bgs_pkg::RST_WEIGHT_CBCR;
        c.alpha_keep   = bgs_pkg::RST_ALPHA_KEEP;
        c.alpha_new    = bgs_pkg::RST_ALPHA_NEW;
        c.box_columns  = bgs_pkg::RST_BOX_COLUMNS;
        c.box_rows     = bgs_pkg::RST_BOX_ROWS;
      end
      SET_MAX: begin
        c.bg_threshold = '1;
        c.fd_threshold = '1;
        c.weight_y     = '1;
        c.weight_cbcr  = '1;
        c.alpha_keep   = 17'h10000;
        c.alpha_new    = 17'h10000;
        c.box_columns  = '1;
        c.box_rows     = '1;
      end
      SET_ZERO: c = '0;
      default: begin
        case ($urandom_range(0, 3))
          0: c.bg_threshold = 32'd0;
          1: c.bg_threshold = $urandom;
          default: c.bg_threshold = $urandom_range(0, 4000000);
        endcase
        case ($urandom_range(0, 3))
          0: c.fd_threshold = 8'd0;
          1: c.fd_threshold = 8'hFF;
          default: c.fd_threshold = 8'($urandom_range(0, 40));
        endcase
        c.weight_y    = $urandom_range(0, 4) == 0 ? 16'hFFFF : 16'($urandom_range(0, 1024));
        c.weight_cbcr = $urandom_range(0, 4) == 0 ? 16'h0000 : 16'($urandom_range(0, 1024));
        c.alpha_keep  = 17'($urandom_range(0, 65536));
        c.alpha_new   = $urandom_range(0, 2) == 0 ? 17'($urandom_range(0, 65536))
                                                  : 17'h10000 - c.alpha_keep;
        // reload box: off, around the hot window, empty, whole frame or random
        fc = 16'(HOT_COL + $urandom_range(0, 4));
        lc = fc + 16'($urandom_range(0, 4));
        fr = 16'(HOT_ROW + $urandom_range(0, 1));
        lr = fr + 16'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0: begin
            lc = 16'd0;
            fc = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
          end
          1: ;
          2: begin
            fc = lc + 16'd1;
            fr = $urandom_range(0, 1) ? lr + 16'd1 : fr;
          end
          3: begin
            fc = 16'd0;
            lc = 16'hFFFF;
            fr = 16'd0;
            lr = 16'hFFFF;
          end
          default: begin
            {lc, fc} = $urandom;
            {lr, fr} = $urandom;
          end
        endcase
        c.box_columns = {lc, fc};
        c.box_rows    = {lr, fr};
      end
    endcase
    return c;
  endfunction

  // send one pixel word, leaving valid high for a back-to-back follower
  task automatic send_pixel(input pix_word_t w);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.op       <= w.op;
    pix_bus.pixel_y  <= w.pixel_y;
    pix_bus.pixel_cb <= w.pixel_cb;
    pix_bus.pixel_cr <= w.pixel_cr;
    pix_bus.column   <= w.column;
    pix_bus.row      <= w.row;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    due_results.push_back(segment_pixel(w));
    if (w.column >= FRAME_W || w.row >= FRAME_H) n_ignored++;
    else if (w.op == bgs_pkg::OP_LOAD) n_loads++;
    else n_segments++;
  endtask

  // stop sending and wait for the pipeline to empty
  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all eight registers while the block is idle
  task automatic apply_config(input bgs_pkg::cfg_t c);
    logic [31:0] vals [8];
    wait_drained();
    vals[bgs_pkg::REG_BG_THRESHOLD] = 32'(c.bg_threshold);
    vals[bgs_pkg::REG_FD_THRESHOLD] = 32'(c.fd_threshold);
    vals[bgs_pkg::REG_WEIGHT_Y]     = 32'(c.weight_y);
    vals[bgs_pkg::REG_WEIGHT_CBCR]  = 32'(c.weight_cbcr);
    vals[bgs_pkg::REG_ALPHA_KEEP]   = 32'(c.alpha_keep);
    vals[bgs_pkg::REG_ALPHA_NEW]    = 32'(c.alpha_new);
    vals[bgs_pkg::REG_BOX_COLUMNS]  = c.box_columns;
    vals[bgs_pkg::REG_BOX_ROWS]     = c.box_rows;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[bgs_pkg::CFG_INDEX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow_cfg = c;
    n_settings++;
  endtask

  // reset settings: extremes of the pixel and of the frame, ignored positions
  task automatic test_directed_cases();
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 255, 255, 255, FRAME_W - 1, FRAME_H - 1));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 255, 255, 255, 0, 0));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 255, 255, 255, FRAME_W - 1, FRAME_H - 1));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 100, 128, 128, 320, 240));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 131, 128, 128, 320, 240));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 130, 128, 128, 320, 240));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 130, 129, 127, 320, 240));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 255, 255, 255, FRAME_W, 0));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 255, 255, 255, 0, FRAME_H));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 255, 255, 255, 1023, 511));
  endtask

  // extreme registers: wide distance, saturated blend, reload box edges
  task automatic test_register_extremes();
    bgs_pkg::cfg_t c;
    c = preset_setting(SET_MAX);
    c.fd_threshold = 8'd0;
    c.box_columns  = {16'd5, 16'd2};
    c.box_rows     = {16'd3, 16'd1};
    apply_config(c);
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 200, 50, 60, 3, 2));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 210, 55, 65, 3, 2));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 255, 255, 255, 10, 10));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 255, 255, 255, 10, 10));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 1, 2, 3, 2, 1));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 9, 9, 9, 2, 1));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 1, 2, 3, 5, 3));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 1, 2, 3, 5, 3));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 1, 2, 3, 6, 3));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 1, 2, 3, 6, 3));
    send_pixel(mk_pixel(bgs_pkg::OP_LOAD, 0, 255, 0, FRAME_W - 1, 0));
    send_pixel(mk_pixel(bgs_pkg::OP_SEGMENT, 255, 0, 255, FRAME_W - 1, 0));
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    apply_config(preset_setting(SET_RESET));
    idle_on = 1'b0;
    res_hold_cycles = 300;
    repeat (60) send_pixel(random_pixel());
    wait_drained();
    idle_on = 1'b1;
  endtask

  // sender sends a burst, waits for all its results, then sends another burst
  task automatic test_sender_pause();
    repeat (30) send_pixel(random_pixel());
    wait_drained();
    repeat (30) send_pixel(random_pixel());
  endtask

  // random frames over several register settings
  task automatic test_random_frames();
    pix_word_t w;
    int        counted;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_config(preset_setting(SET_RESET));
        1: apply_config(preset_setting(SET_MAX));
        2: apply_config(preset_setting(SET_ZERO));
        default: apply_config(preset_setting(SET_RANDOM));
      endcase
      idle_on = (phase % 3) != 2;
      counted = 0;
      while (counted < 250) begin
        w = random_pixel();
        send_pixel(w);
        if (w.column < FRAME_W && w.row < FRAME_H) counted++;
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result ready: random stalls, plus long hold-offs on request
  initial begin : result_ready_gen
    int unsigned stall;
    res_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (res_hold_cycles != 0) begin
        stall = res_hold_cycles;
        res_hold_cycles = 0;
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        res_bus.ready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result word with the oldest pending one
  always @(posedge clk) begin : result_check
    px_result_t want;
    px_result_t got;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.foreground    = res_bus.foreground;
      got.motion        = res_bus.motion;
      got.background_y  = res_bus.background_y;
      got.background_cb = res_bus.background_cb;
      got.background_cr = res_bus.background_cr;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none pending, expected none, actual %h",
                 $time, got);
      end else begin
        want = due_results.pop_front();
        compare_field("foreground", 8'(want.foreground), 8'(got.foreground));
        compare_field("motion", 8'(want.motion), 8'(got.motion));
        compare_field("background_y", want.background_y, got.background_y);
        compare_field("background_cb", want.background_cb, got.background_cb);
        compare_field("background_cr", want.background_cr, got.background_cr);
        if (got.foreground === 1'b1) n_fg++;
        if (got.motion === 1'b1) n_motion++;
      end
    end
  end

  initial begin : run_limit
    #50_000_000;
    $display("background_subtraction_pixel_core verification failed");
    $finish;
  end

  initial begin : run_tests
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    pix_bus.valid    = 1'b0;
    pix_bus.op       = bgs_pkg::OP_LOAD;
    pix_bus.pixel_y  = '0;
    pix_bus.pixel_cb = '0;
    pix_bus.pixel_cr = '0;
    pix_bus.column   = '0;
    pix_bus.row      = '0;
    shadow_cfg       = preset_setting(SET_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_frames();
    wait_drained();

    $display("covered %0d loads, %0d segments and %0d out-of-frame words over %0d settings",
             n_loads, n_segments, n_ignored, n_settings);
    $display("foreground seen %0d times, motion %0d times, %0d mismatches",
             n_fg, n_motion, mismatches);
    if (mismatches == 0)
      $display("background_subtraction_pixel_core verification clean");
    else
      $display("background_subtraction_pixel_core verification failed");
    $finish;
  end

endmodule
